>>> rtl/core/rtpe_pkg.sv
// Package: shared widths, register indexes and limits for the racetrack path error block
`default_nettype none
package rtpe_pkg;
   localparam int unsigned FRAC_BITS_DEFAULT = 8;
   localparam int unsigned RAD_W  = 24;
   localparam int unsigned CS_W   = 16;
   localparam int unsigned POS_W  = 32;
   localparam int unsigned DIST_W = 31;
   localparam int unsigned PCT_W  = 24;
   localparam int unsigned IDX_W  = 2;
   localparam int unsigned DATA_W = 24;
   localparam int unsigned COORD_W = 36;     // rotated coordinate width
   localparam int unsigned DEL_W   = 38;     // delta to turn center
   localparam int unsigned MAG_W   = 34;     // clamped magnitude width
   localparam int unsigned SQ_W    = 2 * MAG_W;
   localparam int unsigned ROOT_W  = MAG_W + 1;
   localparam int unsigned NUM_W   = DIST_W + 14; // d * 10000
   localparam logic [IDX_W-1:0] REG_TURN_RADIUS = 2'd0;
   localparam logic [IDX_W-1:0] REG_LEG_LENGTH  = 2'd1;
   localparam logic [IDX_W-1:0] REG_HEADING_COS = 2'd2;
   localparam logic [IDX_W-1:0] REG_HEADING_SIN = 2'd3;
   localparam logic [MAG_W-1:0] FAR_LIMIT = 34'h081000000;
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
   localparam logic [PCT_W-1:0]  PCT_MAX  = {PCT_W{1'b1}};
   localparam logic [13:0] PCT_SCALE = 14'd10000;
endpackage
`default_nettype wire

>>> rtl/core/rtpe_sqrt.sv
// Pipelined rounded integer square root, one result bit per stage
`default_nettype none
module rtpe_sqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          enable,
   input  wire logic [rtpe_pkg::SQ_W-1:0]     radicand,
   output logic      [rtpe_pkg::ROOT_W-1:0]   root
);
   localparam int unsigned N = rtpe_pkg::SQ_W / 2;
   localparam int unsigned RW = rtpe_pkg::ROOT_W;
   logic [rtpe_pkg::SQ_W-1:0] rem_ff [N+1];
   logic [N-1:0]              q_ff   [N+1];
   logic [rtpe_pkg::SQ_W-1:0] src_ff [N+1];
   always_comb begin
      rem_ff[0] = '0;
      q_ff[0]   = '0;
      src_ff[0] = radicand;
   end
   for (genvar k = 0; k < N; k++) begin : g_stage
      localparam int unsigned SH = 2 * (N - 1 - k);
      logic [rtpe_pkg::SQ_W+1:0] trial;
      logic [rtpe_pkg::SQ_W+1:0] cur;
      logic [rtpe_pkg::SQ_W-1:0] rem_in;
      logic [N-1:0]              q_in;
      always_comb begin
         cur   = {rem_ff[k], 2'b00} | {{rtpe_pkg::SQ_W{1'b0}}, src_ff[k][SH +: 2]};
         trial = {{(rtpe_pkg::SQ_W-N){1'b0}}, q_ff[k], 2'b01};
         if (cur >= trial) begin
            rem_in = rtpe_pkg::SQ_W'(cur - trial);
            q_in   = {q_ff[k][N-2:0], 1'b1};
         end else begin
            rem_in = rtpe_pkg::SQ_W'(cur);
            q_in   = {q_ff[k][N-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k+1] <= rem_in;
            q_ff[k+1]   <= q_in;
            src_ff[k+1] <= src_ff[k];
         end
      end
   end
   // round: remainder s - q^2 greater than q bumps the root
   assign root = (rem_ff[N] > rtpe_pkg::SQ_W'(q_ff[N])) ? RW'(q_ff[N]) + RW'(1) : RW'(q_ff[N]);
   logic unused;
   assign unused = reset ^ (^src_ff[N]);
endmodule
`default_nettype wire

>>> rtl/core/rtpe_div.sv
// Pipelined restoring divider for the percentage quotient, one quotient bit per stage
`default_nettype none
module rtpe_div (
   input  wire logic                          clock,
   input  wire logic                          enable,
   input  wire logic [rtpe_pkg::NUM_W-1:0]    numer,
   input  wire logic [rtpe_pkg::RAD_W-1:0]    denom,
   output logic      [rtpe_pkg::NUM_W-1:0]    quot
);
   localparam int unsigned N = rtpe_pkg::NUM_W;
   localparam int unsigned RW = rtpe_pkg::RAD_W + 1;
   logic [RW-1:0] rem_ff [N+1];
   logic [N-1:0]  num_ff [N+1];
   logic [N-1:0]  q_ff   [N+1];
   logic [rtpe_pkg::RAD_W-1:0] den_ff [N+1];
   always_comb begin
      rem_ff[0] = '0;
      num_ff[0] = numer;
      q_ff[0]   = '0;
      den_ff[0] = denom;
   end
   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [RW:0]   cur;
      logic [RW-1:0] rem_in;
      logic          bit_in;
      always_comb begin
         cur = {rem_ff[k], num_ff[k][N-1-k]};
         if (cur >= {2'b00, den_ff[k]}) begin
            rem_in = RW'(cur - {2'b00, den_ff[k]});
            bit_in = 1'b1;
         end else begin
            rem_in = RW'(cur);
            bit_in = 1'b0;
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k+1] <= rem_in;
            num_ff[k+1] <= num_ff[k];
            den_ff[k+1] <= den_ff[k];
            q_ff[k+1]   <= {q_ff[k][N-2:0], bit_in};
         end
      end
   end
   assign quot = q_ff[N];
   logic unused;
   assign unused = (^rem_ff[N]) ^ (^num_ff[N]) ^ (^den_ff[N]);
endmodule
`default_nettype wire

>>> rtl/core/racetrack_path_error.sv
// Top level: racetrack path distance and percentage error pipeline
`default_nettype none
// Racetrack path error. Each req word carries one east/north offset (units of
// 2^-FRAC_BITS m); the block rotates it by the heading cosine and sine, measures
// the distance to a stadium path (legs on x=0 and x=2r from y=0 to y=L, half
// circle turns at both ends) and returns that distance together with the error
// as hundredths of a percent of the turn radius, both saturating. A new word is
// taken every cycle unless a stalled valid output holds the pipe, which runs
// rotation and geometry, the square root (one root bit per stage), a scaling
// register, the division (one quotient bit per stage) and an output register;
// the bit-per-stage square root and divider set its depth. The whole pipe
// advances together and holds while rsp_stall meets a valid output; rsp_valid
// never waits on it. Radius zero gives 0 percent for zero distance, else
// saturation. Writes to csr only while the block is idle.
module racetrack_path_error #(
   parameter int unsigned FRAC_BITS = rtpe_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [rtpe_pkg::POS_W-1:0] req_east_offset,
   input  wire logic signed [rtpe_pkg::POS_W-1:0] req_north_offset,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [rtpe_pkg::DIST_W-1:0]       rsp_path_distance,
   output logic      [rtpe_pkg::PCT_W-1:0]        rsp_error_percent,
   input  wire logic                              csr_write,
   input  wire logic [rtpe_pkg::IDX_W-1:0]        csr_index,
   input  wire logic [rtpe_pkg::DATA_W-1:0]       csr_data
);
   localparam int unsigned CW = rtpe_pkg::COORD_W;
   localparam int unsigned DW = rtpe_pkg::DEL_W;
   localparam int unsigned MW = rtpe_pkg::MAG_W;
   localparam int unsigned SQRT_LAT = rtpe_pkg::SQ_W / 2;
   localparam int unsigned DIV_LAT  = rtpe_pkg::NUM_W;
   localparam int unsigned LAT = 5 + SQRT_LAT + 1 + DIV_LAT + 1;

   typedef enum logic [1:0] {ZONE_LEG, ZONE_TURN} zone_type;

   // configuration registers
   logic [rtpe_pkg::RAD_W-1:0] radius_ff, leg_ff;
   logic signed [rtpe_pkg::CS_W-1:0] cos_ff, sin_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 24'd256000;
         leg_ff    <= 24'd2560000;
         cos_ff    <= 16'sd16384;
         sin_ff    <= 16'sd0;
      end else if (csr_write) begin
         case (csr_index)
            rtpe_pkg::REG_TURN_RADIUS: radius_ff <= csr_data;
            rtpe_pkg::REG_LEG_LENGTH:  leg_ff    <= csr_data;
            rtpe_pkg::REG_HEADING_COS: cos_ff    <= csr_data[rtpe_pkg::CS_W-1:0];
            rtpe_pkg::REG_HEADING_SIN: sin_ff    <= csr_data[rtpe_pkg::CS_W-1:0];
            default: ;
         endcase
      end
   end

   // the pipe moves whenever the output slot is free or empty
   logic advance;
   logic [LAT-1:0] valid_ff;
   assign advance   = !(valid_ff[LAT-1] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = valid_ff[LAT-1];
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (advance) valid_ff <= {valid_ff[LAT-2:0], req_valid};
   end

   // stage 1: four products
   logic signed [47:0] ec_ff, ns_ff, es_ff, nc_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         ec_ff <= req_east_offset * cos_ff;
         ns_ff <= req_north_offset * sin_ff;
         es_ff <= req_east_offset * sin_ff;
         nc_ff <= req_north_offset * cos_ff;
      end
   end

   // stage 2: rotate with round half up
   logic signed [49:0] xs, ys;
   logic signed [CW-1:0] x_ff, y_ff;
   assign xs = 50'(ec_ff) - 50'(ns_ff) + 50'sd8192;
   assign ys = 50'(es_ff) + 50'(nc_ff) + 50'sd8192;
   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff <= CW'(xs >>> 14);
         y_ff <= CW'(ys >>> 14);
      end
   end

   // stage 3: zone and deltas
   logic signed [DW-1:0] dx_ff, dy_ff, xr_ff;
   zone_type zone_ff;
   logic signed [DW-1:0] r_s, l_s, x_s, y_s;
   assign r_s = DW'(signed'({1'b0, radius_ff}));
   assign l_s = DW'(signed'({1'b0, leg_ff}));
   assign x_s = DW'(x_ff);
   assign y_s = DW'(y_ff);
   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff <= x_s - r_s;
         xr_ff <= x_s - (r_s <<< 1);
         if (y_s >= 0 && y_s <= l_s) begin
            zone_ff <= ZONE_LEG;
            dy_ff   <= '0;
         end else begin
            zone_ff <= ZONE_TURN;
            dy_ff   <= (y_s > l_s) ? y_s - l_s : y_s;
         end
      end
   end

   // stage 4: magnitudes, far check, leg distance
   function automatic logic [DW-1:0] absv(input logic signed [DW-1:0] v);
      absv = v[DW-1] ? DW'(-v) : DW'(v);
   endfunction
   logic [DW-1:0] ax, ay, la, lb;
   logic [DW:0] xfull;
   assign ax = absv(dx_ff);
   assign ay = absv(dy_ff);
   assign xfull = (DW+1)'(signed'(dx_ff)) + (DW+1)'(signed'({1'b0, radius_ff}));
   assign la = xfull[DW] ? DW'(-xfull) : DW'(xfull);
   assign lb = absv(xr_ff);
   logic [MW-1:0] ax_ff, ay_ff;
   logic [DW-1:0] leg_d_ff;
   logic          far_ff;
   zone_type      zone4_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         far_ff   <= (ax >= DW'(rtpe_pkg::FAR_LIMIT)) || (ay >= DW'(rtpe_pkg::FAR_LIMIT));
         ax_ff    <= MW'(ax);
         ay_ff    <= MW'(ay);
         leg_d_ff <= (la < lb) ? la : lb;
         zone4_ff <= zone_ff;
      end
   end

   // stage 5: sum of squares
   logic [rtpe_pkg::SQ_W-1:0] sq_ff;
   always_ff @(posedge clock) begin
      if (advance) sq_ff <= rtpe_pkg::SQ_W'(ax_ff * ax_ff) + rtpe_pkg::SQ_W'(ay_ff * ay_ff);
   end

   // side info delayed alongside the square root
   logic [DW-1:0] legd_d_ff [SQRT_LAT+1];
   logic          far_d_ff  [SQRT_LAT+1];
   zone_type      zone_d_ff [SQRT_LAT+1];
   logic [rtpe_pkg::RAD_W-1:0] rad_d_ff [SQRT_LAT+1];
   always_ff @(posedge clock) begin
      if (advance) begin
         legd_d_ff[0] <= leg_d_ff;
         far_d_ff[0]  <= far_ff;
         zone_d_ff[0] <= zone4_ff;
         rad_d_ff[0]  <= radius_ff;
         for (int i = 1; i <= SQRT_LAT; i++) begin
            legd_d_ff[i] <= legd_d_ff[i-1];
            far_d_ff[i]  <= far_d_ff[i-1];
            zone_d_ff[i] <= zone_d_ff[i-1];
            rad_d_ff[i]  <= rad_d_ff[i-1];
         end
      end
   end

   logic [rtpe_pkg::ROOT_W-1:0] root;
   rtpe_sqrt u_sqrt (
      .clock(clock), .reset(reset), .enable(advance),
      .radicand(sq_ff), .root(root)
   );

   // final distance, saturating; then scale with rounding term
   logic [DW-1:0] h, td, dsel;
   logic [rtpe_pkg::DIST_W-1:0] dist_sat;
   logic [rtpe_pkg::RAD_W-1:0] rad_s;
   assign rad_s = rad_d_ff[SQRT_LAT];
   assign h  = DW'(root);
   assign td = (h >= DW'(rad_s)) ? h - DW'(rad_s) : DW'(rad_s) - h;
   always_comb begin
      if (zone_d_ff[SQRT_LAT] == ZONE_LEG) dsel = legd_d_ff[SQRT_LAT];
      else if (far_d_ff[SQRT_LAT]) dsel = DW'(rtpe_pkg::DIST_MAX);
      else dsel = td;
   end
   assign dist_sat = (dsel > DW'(rtpe_pkg::DIST_MAX)) ? rtpe_pkg::DIST_MAX
                                                       : rtpe_pkg::DIST_W'(dsel);

   logic [rtpe_pkg::DIST_W-1:0] dist_ff;
   logic [rtpe_pkg::NUM_W-1:0]  num_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         dist_ff <= dist_sat;
         num_ff  <= rtpe_pkg::NUM_W'(dist_sat * rtpe_pkg::PCT_SCALE)
                  + rtpe_pkg::NUM_W'(rad_s >> 1);
      end
   end

   // radius tap 0 lines up with num_ff, the last tap with the quotient
   logic [rtpe_pkg::DIST_W-1:0] dist_d_ff [DIV_LAT];
   logic [rtpe_pkg::RAD_W-1:0]  rad2_d_ff [DIV_LAT+1];
   always_ff @(posedge clock) begin
      if (advance) begin
         dist_d_ff[0] <= dist_ff;
         rad2_d_ff[0] <= rad_d_ff[SQRT_LAT];
         for (int i = 1; i < DIV_LAT; i++) begin
            dist_d_ff[i] <= dist_d_ff[i-1];
            rad2_d_ff[i] <= rad2_d_ff[i-1];
         end
         rad2_d_ff[DIV_LAT] <= rad2_d_ff[DIV_LAT-1];
      end
   end

   logic [rtpe_pkg::NUM_W-1:0] quot;
   rtpe_div u_div (
      .clock(clock), .enable(advance),
      .numer(num_ff), .denom(rad2_d_ff[0]), .quot(quot)
   );

   // output register: saturate the quotient, treat zero radius apart
   logic [rtpe_pkg::DIST_W-1:0] dist_o;
   logic [rtpe_pkg::RAD_W-1:0]  rad_o;
   assign dist_o = dist_d_ff[DIV_LAT-1];
   assign rad_o  = rad2_d_ff[DIV_LAT];
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_path_distance <= dist_o;
         if (rad_o == '0)
            rsp_error_percent <= (dist_o == '0) ? '0 : rtpe_pkg::PCT_MAX;
         else if (quot > rtpe_pkg::NUM_W'(rtpe_pkg::PCT_MAX))
            rsp_error_percent <= rtpe_pkg::PCT_MAX;
         else
            rsp_error_percent <= rtpe_pkg::PCT_W'(quot);
      end
   end

   logic unused;
   assign unused = (FRAC_BITS == 0);
endmodule
`default_nettype wire
